// ===== design/clap_pkg.sv =====
// ---------------------------------------------------------------------------
// clap_pkg
// Shared types and constants for the hand-clap noise burst voice.
// ---------------------------------------------------------------------------
`default_nettype none

package clap_pkg;

  localparam int MUL_AW = 48;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TRIG = 1'b1;

  localparam logic [2:0] REG_VOLUME      = 3'd0;
  localparam logic [2:0] REG_AMP_DECAY   = 3'd1;
  localparam logic [2:0] REG_BURST_DECAY = 3'd2;
  localparam logic [2:0] REG_BP_FREQ     = 3'd3;
  localparam logic [2:0] REG_GAP1        = 3'd4;
  localparam logic [2:0] REG_GAP2        = 3'd5;
  localparam logic [2:0] REG_GAP3        = 3'd6;
  localparam logic [2:0] REG_TAIL        = 3'd7;

  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] NOISE_SEED = 32'd98765;
  localparam logic [23:0] AMP_FULL   = 24'hFFFFFF;
  localparam logic [15:0] BURST_FULL = 16'hFFFF;
  localparam logic [23:0] AMP_FLOOR  = 24'd1678;
  localparam logic [15:0] BURST_KNEE = 16'd9830;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;
  localparam logic [16:0] GAIN_LOW   = 17'd13107;

  localparam logic signed [47:0] F24_MAX = 48'sd8388607;
  localparam logic signed [47:0] F24_MIN = -48'sd8388608;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  typedef enum logic [3:0] {
    STP_LCG, STP_BURST, STP_BAND, STP_LOW, STP_AMP,
    STP_GAIN, STP_VOL, STP_STRIKE, STP_DECAY
  } step_t;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic        [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [MUL_PW-1:0] p;
  } mul_rsp_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > F24_MAX) r = 24'sh7FFFFF;
    else if (v < F24_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/clap_if.sv =====
// ---------------------------------------------------------------------------
// clap_in_if / clap_out_if
// Valid/ready channels for sample items and mixed results.
// ---------------------------------------------------------------------------
`default_nettype none

interface clap_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [15:0]                    velocity;
  logic signed [SAMPLE_WIDTH-1:0] in_left;
  logic signed [SAMPLE_WIDTH-1:0] in_right;
  modport source (output valid, opcode, velocity, in_left, in_right, input ready);
  modport sink   (input valid, opcode, velocity, in_left, in_right, output ready);
endinterface

interface clap_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;
  logic                           voice_active;
  modport source (output valid, out_left, out_right, voice_active, input ready);
  modport sink   (input valid, out_left, out_right, voice_active, output ready);
endinterface

`default_nettype wire

// ===== design/clap_noise_burst_voice.sv =====
// ---------------------------------------------------------------------------
// clap_noise_burst_voice
// Hand-clap voice: lcg noise, four-burst gate, svf bandpass, envelopes,
// mixed onto a stereo sample stream with saturation.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | opcode, velocity, in_left, in_right
//  out_ch  | out | valid/ready       | out_left, out_right, voice_active
//  cfg_*   | in  | cfg_we, no stall  | cfg_index, cfg_wdata
//
//  trigger and idle tick: result register loaded directly at accept
//  sounding tick: 9 products on one bit-serial multiplier
//  that handles one bit of its b operand per cycle
//  synchronous reset; a waiting result holds the block in its output state
//  until out_ch takes it, and a new item is taken only when idle
// ---------------------------------------------------------------------------
`default_nettype none

module clap_noise_burst_voice
  import clap_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int GAP_WIDTH    = 12
) (
  input  wire              clk,
  input  wire              rst_n,
  clap_in_if.sink          in_ch,
  clap_out_if.source       out_ch,
  input  wire              cfg_we,
  input  wire  [2:0]       cfg_index,
  input  wire  [23:0]      cfg_wdata
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int RSH = (SW <= 22) ? 22 - SW : 0;
  localparam int LSH = (SW > 22) ? SW - 22 : 0;
  localparam logic signed [47:0] SMAX = (48'sd1 <<< (SW - 1)) - 48'sd1;
  localparam logic signed [47:0] SMIN = -(48'sd1 <<< (SW - 1));
  localparam logic [GAP_WIDTH-1:0] GAP_MAX = '1;

  // configuration
  logic [15:0]          volume_r, bdecay_r;
  logic [23:0]          adecay_r;
  logic [16:0]          freq_r;
  logic [GAP_WIDTH-1:0] gap1_r, gap2_r, gap3_r, tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= 16'd45875;
      adecay_r <= 24'd16776217;
      bdecay_r <= 16'd65195;
      freq_r   <= 17'd12847;
      gap1_r   <= GAP_WIDTH'(384);
      gap2_r   <= GAP_WIDTH'(528);
      gap3_r   <= GAP_WIDTH'(672);
      tail_r   <= GAP_WIDTH'(288);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLUME:      volume_r <= cfg_wdata[15:0];
        REG_AMP_DECAY:   adecay_r <= cfg_wdata;
        REG_BURST_DECAY: bdecay_r <= cfg_wdata[15:0];
        REG_BP_FREQ:     freq_r   <= cfg_wdata[16:0];
        REG_GAP1:        gap1_r   <= cfg_wdata[GAP_WIDTH-1:0];
        REG_GAP2:        gap2_r   <= cfg_wdata[GAP_WIDTH-1:0];
        REG_GAP3:        gap3_r   <= cfg_wdata[GAP_WIDTH-1:0];
        REG_TAIL:        tail_r   <= cfg_wdata[GAP_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  // voice state
  state_t               state_r, state_nxt;
  step_t                step_r, step_nxt;
  logic                 go_r, go_nxt;
  logic                 sounding_r, sounding_nxt;
  logic [15:0]          strike_r, strike_nxt;
  logic [23:0]          amp_r, amp_nxt;
  logic [15:0]          benv_r, benv_nxt;
  logic [2:0]           bidx_r, bidx_nxt;
  logic [GAP_WIDTH-1:0] btimer_r, btimer_nxt;
  logic [31:0]          noise_r, noise_nxt;
  logic signed [23:0]   low_r, low_nxt;
  logic signed [23:0]   band_r, band_nxt;
  logic                 bact_r, bact_nxt;
  logic                 gain_hi_r, gain_hi_nxt;
  logic signed [47:0]   vacc_r, vacc_nxt;
  logic signed [SW-1:0] inl_r, inl_nxt, inr_r, inr_nxt;
  logic signed [SW-1:0] resl_r, resl_nxt, resr_r, resr_nxt;
  logic                 resact_r, resact_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic signed [SW-1:0] outl_r, outl_nxt, outr_r, outr_nxt;
  logic                 oact_r, oact_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  clap_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  logic signed [31:0]          noise_sh;
  logic signed [47:0]          high;
  logic signed [47:0]          p_hi16, p_hi24, voice, fsum, lsum, rsum;
  logic [GAP_WIDTH-1:0]        tinc, gap;
  logic [15:0]                 benv_g;
  logic                        accept;

  assign accept = in_ch.valid && in_ch.ready;

  // multiplier operands per step
  always_comb begin
    noise_sh = $signed(noise_r) >>> 10;
    high = 48'(noise_sh) - 48'(low_r) - (48'(band_r) >>> 1);
    mreq.start = go_r;
    unique case (step_r)
      STP_LCG:    begin mreq.a = {16'b0, noise_r};  mreq.b = LCG_MUL;        end
      STP_BURST:  begin mreq.a = {32'b0, benv_r};   mreq.b = {16'b0, bdecay_r}; end
      STP_BAND:   begin mreq.a = high;              mreq.b = {15'b0, freq_r}; end
      STP_LOW:    begin mreq.a = 48'(band_r);       mreq.b = {15'b0, freq_r}; end
      STP_AMP:    begin mreq.a = 48'(band_r);       mreq.b = {8'b0, amp_r};   end
      STP_GAIN:   begin
        mreq.a = vacc_r;
        mreq.b = {15'b0, (gain_hi_r ? GAIN_ONE : GAIN_LOW)};
      end
      STP_VOL:    begin mreq.a = vacc_r;            mreq.b = {16'b0, volume_r}; end
      STP_STRIKE: begin mreq.a = vacc_r;            mreq.b = {16'b0, strike_r}; end
      STP_DECAY:  begin mreq.a = {24'b0, amp_r};    mreq.b = {8'b0, adecay_r}; end
      default:    begin mreq.a = '0;                mreq.b = '0;              end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    go_nxt       = 1'b0;
    sounding_nxt = sounding_r;
    strike_nxt   = strike_r;
    amp_nxt      = amp_r;
    benv_nxt     = benv_r;
    bidx_nxt     = bidx_r;
    btimer_nxt   = btimer_r;
    noise_nxt    = noise_r;
    low_nxt      = low_r;
    band_nxt     = band_r;
    bact_nxt     = bact_r;
    gain_hi_nxt  = gain_hi_r;
    vacc_nxt     = vacc_r;
    inl_nxt      = inl_r;
    inr_nxt      = inr_r;
    resl_nxt     = resl_r;
    resr_nxt     = resr_r;
    resact_nxt   = resact_r;
    ovalid_nxt   = ovalid_r && !out_ch.ready;
    outl_nxt     = outl_r;
    outr_nxt     = outr_r;
    oact_nxt     = oact_r;

    tinc = (btimer_r != GAP_MAX) ? btimer_r + 1'b1 : btimer_r;
    priority case (bidx_r)
      3'd0:    gap = gap1_r;
      3'd1:    gap = gap2_r;
      default: gap = gap3_r;
    endcase
    benv_g = benv_r;

    p_hi16 = $signed(mrsp.p[63:16]);
    p_hi24 = $signed(mrsp.p[71:24]);
    voice  = (p_hi16 >>> RSH) <<< LSH;
    fsum   = '0;
    lsum   = 48'(inl_r) + vacc_r;
    rsum   = 48'(inr_r) + vacc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          inl_nxt = in_ch.in_left;
          inr_nxt = in_ch.in_right;
          resl_nxt = in_ch.in_left;
          resr_nxt = in_ch.in_right;
          if (in_ch.opcode == OP_TRIG) begin
            strike_nxt   = in_ch.velocity;
            sounding_nxt = 1'b1;
            amp_nxt      = AMP_FULL;
            benv_nxt     = BURST_FULL;
            bidx_nxt     = 3'd0;
            btimer_nxt   = '0;
            resact_nxt   = 1'b1;
            state_nxt    = ST_OUT;
          end else if (sounding_r) begin
            // burst gate advances at the start of the tick
            bact_nxt = (bidx_r < 3'd4);
            if (bidx_r < 3'd4) begin
              if (bidx_r < 3'd3 && tinc >= gap) begin
                bidx_nxt   = bidx_r + 3'd1;
                benv_g     = BURST_FULL;
                btimer_nxt = '0;
              end else begin
                btimer_nxt = tinc;
                if (bidx_r >= 3'd3 && tinc > tail_r) bidx_nxt = 3'd4;
              end
              gain_hi_nxt = benv_g > BURST_KNEE;
            end else begin
              gain_hi_nxt = 1'b1;
            end
            benv_nxt  = benv_g;
            step_nxt  = STP_LCG;
            go_nxt    = 1'b1;
            state_nxt = ST_RUN;
          end else begin
            resact_nxt = 1'b0;
            state_nxt  = ST_OUT;
          end
        end
      end
      ST_RUN: begin
        if (mrsp.done) begin
          go_nxt = 1'b1;
          unique case (step_r)
            STP_LCG: begin
              noise_nxt = mrsp.p[31:0] + LCG_ADD;
              step_nxt  = STP_BURST;
            end
            STP_BURST: begin
              if (bact_r) benv_nxt = mrsp.p[31:16];
              step_nxt = STP_BAND;
            end
            STP_BAND: begin
              fsum     = 48'(band_r) + p_hi16;
              band_nxt = sat24(fsum);
              step_nxt = STP_LOW;
            end
            STP_LOW: begin
              fsum     = 48'(low_r) + p_hi16;
              low_nxt  = sat24(fsum);
              step_nxt = STP_AMP;
            end
            STP_AMP: begin
              vacc_nxt = p_hi24;
              step_nxt = STP_GAIN;
            end
            STP_GAIN: begin
              vacc_nxt = p_hi16;
              step_nxt = STP_VOL;
            end
            STP_VOL: begin
              vacc_nxt = p_hi16;
              step_nxt = STP_STRIKE;
            end
            STP_STRIKE: begin
              vacc_nxt = voice;
              step_nxt = STP_DECAY;
            end
            STP_DECAY: begin
              go_nxt  = 1'b0;
              amp_nxt = mrsp.p[47:24];
              resact_nxt = 1'b1;
              if (mrsp.p[47:24] < AMP_FLOOR) begin
                sounding_nxt = 1'b0;
                low_nxt      = '0;
                band_nxt     = '0;
                resact_nxt   = 1'b0;
              end
              resl_nxt = (lsum > SMAX) ? SMAX[SW-1:0] :
                         (lsum < SMIN) ? SMIN[SW-1:0] : lsum[SW-1:0];
              resr_nxt = (rsum > SMAX) ? SMAX[SW-1:0] :
                         (rsum < SMIN) ? SMIN[SW-1:0] : rsum[SW-1:0];
              state_nxt = ST_OUT;
            end
            default: go_nxt = 1'b0;
          endcase
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          outl_nxt   = resl_r;
          outr_nxt   = resr_r;
          oact_nxt   = resact_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    bact_r    <= bact_nxt;
    gain_hi_r <= gain_hi_nxt;
    vacc_r    <= vacc_nxt;
    inl_r     <= inl_nxt;
    inr_r     <= inr_nxt;
    resl_r    <= resl_nxt;
    resr_r    <= resr_nxt;
    resact_r  <= resact_nxt;
    outl_r    <= outl_nxt;
    outr_r    <= outr_nxt;
    oact_r    <= oact_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= STP_LCG;
      go_r       <= 1'b0;
      sounding_r <= 1'b0;
      strike_r   <= '0;
      amp_r      <= '0;
      benv_r     <= '0;
      bidx_r     <= '0;
      btimer_r   <= '0;
      noise_r    <= NOISE_SEED;
      low_r      <= '0;
      band_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      go_r       <= go_nxt;
      sounding_r <= sounding_nxt;
      strike_r   <= strike_nxt;
      amp_r      <= amp_nxt;
      benv_r     <= benv_nxt;
      bidx_r     <= bidx_nxt;
      btimer_r   <= btimer_nxt;
      noise_r    <= noise_nxt;
      low_r      <= low_nxt;
      band_r     <= band_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = ovalid_r;
  assign out_ch.out_left     = outl_r;
  assign out_ch.out_right    = outr_r;
  assign out_ch.voice_active = oact_r;

`ifndef SYNTHESIS
  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mrsp.busy)
    else $error("multiplier busy while idle");

  a_silent_filter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !sounding_r |-> (low_r == '0 && band_r == '0))
    else $error("filter state kept while silent");

  a_burst_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r <= 3'd4)
    else $error("burst index out of range");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == ST_RUN))
    else $error("product finished outside a tick");
`endif

endmodule

`default_nettype wire

// ===== design/clap_ser_mul.sv =====
// ---------------------------------------------------------------------------
// clap_ser_mul
// Bit-serial shift-add multiplier: signed a times unsigned b, one bit of b
// per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module clap_ser_mul
  import clap_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CW = $clog2(MUL_BW + 1);

  logic signed [MUL_AW-1:0] a_r;
  logic signed [MUL_AW:0]   hi_r, hi_nxt;
  logic        [MUL_BW-1:0] lo_r, lo_nxt;
  logic        [CW-1:0]     cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic signed [MUL_AW:0]   sum;

  always_comb begin
    sum = hi_r + (lo_r[0] ? {a_r[MUL_AW-1], a_r} : '0);
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = req.b;
      cnt_nxt  = CW'(MUL_BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[MUL_BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) a_r <= req.a;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.p    = {hi_r[MUL_AW-1:0], lo_r};

endmodule

`default_nettype wire
